// File: rtl/pcr_pkg.sv
// Shared types, constants and helpers for the palette code to RGB565 decoder.
// No dependencies; compiled first.
package pcr_pkg;

  localparam int PALETTE_DEPTH_DEF  = 256;
  localparam int MAX_CODE_CHARS_DEF = 4;

  localparam int CODE_W     = 32;
  localparam int COLOR_W    = 16;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 8;
  localparam int CHAN_W     = 8;
  localparam int CPP_W      = 3;
  localparam int CNT_REG_W  = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CHARS_PER_PIXEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT     = CFG_IDX_W'(1);

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_SCAN,
    SRCH_DONE
  } srch_state_t;

  // search launch from the front end
  typedef struct packed {
    logic              go;
    logic              empty;
    logic [CODE_W-1:0] code;
  } srch_cmd_t;

  // search outcome, valid for one cycle
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [COLOR_W-1:0] color;
  } srch_result_t;

  function automatic logic [COLOR_W-1:0] rgb565(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: rtl/pcr_if.sv
// Handshake channels of the palette decoder: item input, result output, config writes.
// Depends on pcr_pkg.
interface pcr_item_if import pcr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [CHAR_W-1:0]   char_byte;
  logic [IDX_W-1:0]    entry_index;
  logic [CODE_W-1:0]   entry_code;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;

  modport source (output valid, action, char_byte, entry_index, entry_code, red, green, blue,
                  input ready);
  modport sink   (input valid, action, char_byte, entry_index, entry_code, red, green, blue,
                  output ready);
endinterface

interface pcr_result_if import pcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_rgb565;
  logic               matched;

  modport source (output valid, pixel_rgb565, matched, input ready);
  modport sink   (input valid, pixel_rgb565, matched, output ready);
endinterface

interface pcr_cfg_if import pcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pcr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pcr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pcr_search.sv
// Linear palette search: one RAM read issued per cycle, compare on returned data.
// Depends on pcr_pkg; drives the read port of pcr_ram in the top level.
module pcr_search import pcr_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srch_cmd_t                        cmd,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] last,
  input  logic                             out_free,
  output logic                             busy,
  output logic                             rd_en,
  output logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
  input  logic [CODE_W-1:0]                rd_code,
  input  logic [COLOR_W-1:0]               rd_color,
  output srch_result_t                     res
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  srch_state_t        state, state_next;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      last_q;
  logic [CODE_W-1:0]  code_q;
  logic               rd_pend;
  logic               rd_last;
  logic               found_q;
  logic [COLOR_W-1:0] color_q;
  logic               hit;
  logic               stop;

  assign hit  = rd_pend && (rd_code == code_q);
  assign stop = hit || (rd_pend && rd_last);

  always_comb begin
    state_next = state;
    case (state)
      SRCH_IDLE: begin
        if (cmd.go) begin
          state_next = cmd.empty ? SRCH_DONE : SRCH_SCAN;
        end
      end
      SRCH_SCAN: begin
        if (stop) begin
          state_next = SRCH_DONE;
        end
      end
      SRCH_DONE: begin
        if (out_free) begin
          state_next = SRCH_IDLE;
        end
      end
      default: state_next = SRCH_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != SRCH_IDLE);
    rd_en     = (state == SRCH_SCAN) && !stop;
    rd_addr   = idx;
    res.valid = (state == SRCH_DONE) && out_free;
    res.found = found_q;
    res.color = color_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SRCH_IDLE;
      rd_pend <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        SRCH_IDLE: begin
          rd_pend <= 1'b0;
          if (cmd.go) begin
            found_q <= 1'b0;
          end
        end
        SRCH_SCAN: begin
          rd_pend <= rd_en;
          if (hit) begin
            found_q <= 1'b1;
          end
        end
        default: rd_pend <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == SRCH_IDLE && cmd.go) begin
      code_q <= cmd.code;
      last_q <= last;
      idx    <= '0;
    end else if (rd_en) begin
      idx <= idx + AW'(1);
    end
    if (rd_en) begin
      rd_last <= (idx == last_q);
    end
    if (state == SRCH_SCAN && hit) begin
      color_q <= rd_color;
    end
  end

endmodule

// File: rtl/palette_code_to_rgb565.sv
// Palette code to RGB565 decoder. Load and non-final pixel requests start no search.
// A final character starts a linear palette scan, one RAM read per cycle, over
// N = min(color_count, PALETTE_DEPTH) slots: it ends on a hit in slot k or after slot N-1 on a
// miss (at once when N is 0), the result is registered, and the next request is taken once
// the search is idle again; a stalled result holds the search in its done state.
// Sync reset clears accumulator, search, output valid; chars_per_pixel 1, color_count 0.
module palette_code_to_rgb565 import pcr_pkg::*; #(
  parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
  parameter int MAX_CODE_CHARS = MAX_CODE_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pcr_item_if.sink      item,
  pcr_result_if.source  result,
  pcr_cfg_if.sink       cfg
);

  localparam int AW     = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
  localparam int WORD_W = CODE_W + COLOR_W;

  // config registers
  logic [CPP_W-1:0]     chars_per_pixel;
  logic [CNT_REG_W-1:0] color_count;

  // pixel code assembly
  logic [CODE_W-1:0]    code_acc;
  logic [CPP_W-1:0]     char_cnt;
  logic [CODE_W-1:0]    code_shift;
  logic [CPP_W-1:0]     cnt_inc;
  logic [CPP_W-1:0]     cpp_eff;
  logic                 code_done;

  // search count clamp
  logic [CMP_W-1:0]     count_ext;
  logic [CNT_W-1:0]     count_eff;
  logic [AW-1:0]        search_last;

  // request handshake
  logic                 accept;
  logic                 is_load;
  logic                 is_pixel;
  logic                 busy;

  // palette RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  srch_cmd_t            cmd;
  srch_result_t         res;

  // result register
  logic                 out_valid;
  logic [COLOR_W-1:0]   out_rgb;
  logic                 out_matched;
  logic                 out_free;

  // config port: always ready, indexes beyond the register list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_pixel <= CPP_W'(1);
      color_count     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CHARS_PER_PIXEL: chars_per_pixel <= cfg.data[CPP_W-1:0];
        REG_COLOR_COUNT:     color_count     <= cfg.data[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // requests are taken only while no search is running; a waiting result does not block
  assign item.ready = !busy;
  assign accept     = item.valid && item.ready;
  assign is_load    = accept && (item.action == ACTION_LOAD);
  assign is_pixel   = accept && (item.action == ACTION_PIXEL);

  // effective chars per pixel: zero acts as one, clamp at the maximum
  always_comb begin
    if (chars_per_pixel == '0) begin
      cpp_eff = CPP_W'(1);
    end else if (chars_per_pixel > CPP_W'(MAX_CODE_CHARS)) begin
      cpp_eff = CPP_W'(MAX_CODE_CHARS);
    end else begin
      cpp_eff = chars_per_pixel;
    end
  end

  // first character ends up most significant; >= so a shrunk setting completes at once
  assign code_shift = {code_acc[CODE_W-CHAR_W-1:0], item.char_byte};
  assign cnt_inc    = char_cnt + CPP_W'(1);
  assign code_done  = (cnt_inc >= cpp_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_acc <= '0;
      char_cnt <= '0;
    end else if (is_pixel) begin
      if (code_done) begin
        code_acc <= '0;
        char_cnt <= '0;
      end else begin
        code_acc <= code_shift;
        char_cnt <= cnt_inc;
      end
    end
  end

  // searched entries: color_count clamped to the palette depth
  assign count_ext   = CMP_W'(color_count);
  assign count_eff   = (count_ext > CMP_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                           : count_ext[CNT_W-1:0];
  assign search_last = AW'(count_eff - CNT_W'(1));

  assign cmd.go    = is_pixel && code_done;
  assign cmd.empty = (count_eff == '0);
  assign cmd.code  = code_shift;

  // palette writes; slots at or past the depth are ignored
  assign ram_we    = is_load && (32'(item.entry_index) < 32'(PALETTE_DEPTH));
  assign ram_waddr = AW'(item.entry_index);
  assign ram_wdata = {item.entry_code, rgb565(item.red, item.green, item.blue)};

  pcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // writes happen only while the search is idle, so no read/write overlap to forward
  pcr_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .last     (search_last),
    .out_free (out_free),
    .busy     (busy),
    .rd_en    (ram_re),
    .rd_addr  (ram_raddr),
    .rd_code  (ram_rdata[WORD_W-1:COLOR_W]),
    .rd_color (ram_rdata[COLOR_W-1:0]),
    .res      (res)
  );

  // result register parts the search from the downstream stall
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_rgb     <= res.found ? res.color : '0;
      out_matched <= res.found;
    end
  end

  assign result.valid        = out_valid;
  assign result.pixel_rgb565 = out_rgb;
  assign result.matched      = out_matched;

endmodule

// File: rtl/pcr_checker.sv
// Port-level assertions for palette_code_to_rgb565, attached by bind.
// Depends on pcr_pkg and the top level's interface ports.
module pcr_checker import pcr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               item_action,
  input logic               result_valid,
  input logic               result_ready,
  input logic [COLOR_W-1:0] result_rgb,
  input logic               result_matched
);

  // a stalled result keeps its valid and payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_rgb)
                                      && $stable(result_matched))
    else $error("result changed while stalled");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_matched |-> result_rgb == '0)
    else $error("unmatched result carries a colour");

  // a palette load never launches a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_valid && item_ready && item_action == ACTION_LOAD))
    else $error("result raised straight after a palette load");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind palette_code_to_rgb565 pcr_checker u_pcr_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_action    (item.action),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_rgb     (result.pixel_rgb565),
  .result_matched (result.matched)
);
